### sv/keyed_slot_table_core_assert.svh
// assertion macros for the keyed slot table core
// used by the top level; expects clk and rst_n in the including scope
`ifndef KEYED_SLOT_TABLE_CORE_ASSERT_SVH
`define KEYED_SLOT_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define KST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define KST_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KST_ASSERT(label, prop, msg)
`define KST_ASSERT_ANY(label, prop, msg)
`endif

`endif

### sv/ksl_pkg.sv
// shared types, sizes and helpers for the keyed slot table
// no dependencies
package ksl_pkg;

  localparam int NUM_BLOCKS      = 4;
  localparam int SLOTS_PER_BLOCK = 8;
  localparam int TOTAL_SLOTS     = NUM_BLOCKS * SLOTS_PER_BLOCK;
  localparam int SLOT_W          = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;

  localparam int KEY_W    = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int SLOT_F_W = 5;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  localparam slot_idx_t LAST_IDX = SLOT_W'(TOTAL_SLOTS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP  = 2'd0,
    OP_RESERVE = 2'd1,
    OP_REMOVE  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND  = 2'd0,
    ST_NEW    = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // result of comparing one stored entry against the request key
  typedef struct packed {
    logic hit;
    logic free;
  } cmp_t;

  // true for the three defined operation codes
  function automatic logic op_known(input logic [OP_W-1:0] op);
    return (op == OP_LOOKUP) || (op == OP_RESERVE) || (op == OP_REMOVE);
  endfunction

  // slot index as seen on the result field, masked or zero extended
  function automatic logic [SLOT_F_W-1:0] to_slot_field(input slot_idx_t idx);
    logic [SLOT_W+SLOT_F_W-1:0] ext;
    ext = {{SLOT_F_W{1'b0}}, idx};
    return ext[SLOT_F_W-1:0];
  endfunction

endpackage

### sv/ksl_req_if.sv
// request channel carrying an operation and a key
// depends on ksl_pkg
interface ksl_req_if;
  import ksl_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [KEY_W-1:0] key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

### sv/ksl_rsp_if.sv
// result channel carrying a status and a slot index
// depends on ksl_pkg
interface ksl_rsp_if;
  import ksl_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_F_W-1:0] slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink   (input valid, input status, input slot, output ready);
endinterface

### sv/ksl_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module ksl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/ksl_match.sv
// shared compare unit: checks one stored entry against the request key
// depends on ksl_pkg
module ksl_match (
  input  logic [ksl_pkg::KEY_W-1:0] entry_key,
  input  logic                      entry_valid,
  input  logic [ksl_pkg::KEY_W-1:0] req_key,
  output ksl_pkg::cmp_t             cmp
);
  import ksl_pkg::*;

  // an invalid entry never hits and counts as free, and request keys are never zero
  always_comb begin
    cmp.hit  = entry_valid && (entry_key == req_key);
    cmp.free = !entry_valid;
  end

endmodule

### sv/keyed_slot_table_core.sv
// keyed slot table: scans the slots one per cycle through a shared comparator
// results: a scanned request puts its result in the output register once a slot
//   hits or the last slot has been compared, so an early hit ends the scan sooner;
//   a zero key or unknown operation skips the scan and is reported as absent
// accept: a new request is taken only in idle, after the last result has entered the
//   output register; that handoff waits while an earlier result is still not taken
// reset: synchronous, clears all slot valid bits so every slot is free
module keyed_slot_table_core (
  input  logic            clk,
  input  logic            rst_n,
  ksl_req_if.sink         in_if,
  ksl_rsp_if.source       out_if
);
  import ksl_pkg::*;

  `include "keyed_slot_table_core_assert.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  op_t                    op_r, op_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  slot_idx_t              rd_idx_r, rd_idx_nxt;
  logic                   issue_r, issue_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  slot_idx_t              cmp_idx_r, cmp_idx_nxt;
  logic                   free_fnd_r, free_fnd_nxt;
  slot_idx_t              free_idx_r, free_idx_nxt;
  logic [TOTAL_SLOTS-1:0] valid_r, valid_nxt;
  status_t                res_status_r, res_status_nxt;
  slot_idx_t              res_slot_r, res_slot_nxt;
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [SLOT_F_W-1:0]    out_slot_r, out_slot_nxt;

  logic                   in_fire;
  logic                   rsp_free;
  logic                   rd_en;
  logic                   wr_en;
  slot_idx_t              free_sel;
  logic                   free_any;
  logic [KEY_W-1:0]       rd_data;
  cmp_t                   cmp;

  // key store
  ksl_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TOTAL_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (free_sel),
    .wr_data (key_r),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  // shared comparator
  ksl_match u_match (
    .entry_key   (rd_data),
    .entry_valid (valid_r[cmp_idx_r]),
    .req_key     (key_r),
    .cmp         (cmp)
  );

  // handshake
  assign in_if.ready   = (state_r == S_IDLE);
  assign in_fire       = in_if.valid && in_if.ready;
  assign rsp_free      = !out_valid_r || out_if.ready;
  assign out_if.valid  = out_valid_r;
  assign out_if.status = out_status_r;
  assign out_if.slot   = out_slot_r;

  // lowest free slot seen so far, the current one included
  assign free_any = free_fnd_r || cmp.free;
  assign free_sel = free_fnd_r ? free_idx_r : cmp_idx_r;
  assign rd_en    = (state_r == S_SCAN) && issue_r;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    rd_idx_nxt     = rd_idx_r;
    issue_nxt      = issue_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    free_fnd_nxt   = free_fnd_r;
    free_idx_nxt   = free_idx_r;
    valid_nxt      = valid_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    wr_en          = 1'b0;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt  = op_t'(in_if.operation);
          key_nxt = in_if.key;
          if ((in_if.key == '0) || !op_known(in_if.operation)) begin
            res_status_nxt = ST_ABSENT;
            res_slot_nxt   = '0;
            state_nxt      = S_DONE;
          end else begin
            rd_idx_nxt   = '0;
            issue_nxt    = 1'b1;
            cmp_vld_nxt  = 1'b0;
            free_fnd_nxt = 1'b0;
            state_nxt    = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // read one slot per cycle
        if (issue_r) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
          issue_nxt  = (rd_idx_r != LAST_IDX);
        end
        cmp_vld_nxt = issue_r;
        cmp_idx_nxt = rd_idx_r;

        // compare the slot read last cycle
        if (cmp_vld_r) begin
          if (cmp.free && !free_fnd_r) begin
            free_fnd_nxt = 1'b1;
            free_idx_nxt = cmp_idx_r;
          end
          if (cmp.hit) begin
            res_status_nxt = ST_FOUND;
            res_slot_nxt   = cmp_idx_r;
            if (op_r == OP_REMOVE) begin
              valid_nxt[cmp_idx_r] = 1'b0;
            end
            issue_nxt   = 1'b0;
            cmp_vld_nxt = 1'b0;
            state_nxt   = S_DONE;
          end else if (cmp_idx_r == LAST_IDX) begin
            res_slot_nxt = '0;
            if (op_r == OP_RESERVE) begin
              if (free_any) begin
                wr_en               = 1'b1;
                valid_nxt[free_sel] = 1'b1;
                res_status_nxt      = ST_NEW;
                res_slot_nxt        = free_sel;
              end else begin
                res_status_nxt = ST_FULL;
              end
            end else begin
              res_status_nxt = ST_ABSENT;
            end
            issue_nxt   = 1'b0;
            cmp_vld_nxt = 1'b0;
            state_nxt   = S_DONE;
          end
        end
      end

      S_DONE: begin
        // hand the result to the output register
        if (rsp_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = to_slot_field(res_slot_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
      free_fnd_r  <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      free_fnd_r  <= free_fnd_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  // checks
  `KST_ASSERT(a_cmp_in_scan, cmp_vld_r |-> (state_r == S_SCAN), "compare outside a scan")
  `KST_ASSERT(a_wr_at_scan_end, wr_en |-> (cmp_vld_r && (op_r == OP_RESERVE)), "stray write")
  `KST_ASSERT(a_done_loads_out, ((state_r == S_DONE) && rsp_free) |=> out_valid_r, "result lost")
  `KST_ASSERT(a_new_grows, $past(wr_en) |-> ($countones(valid_r) == $countones($past(valid_r)) + 1), "no slot taken")
  `KST_ASSERT_ANY(a_reset_idle, !rst_n |=> ((state_r == S_IDLE) && !out_valid_r), "reset did not idle")

endmodule
